// ===== rtl/core/sha1_block_hash_unit_macros.svh =====
// Assertion macros for the SHA-1 block hash unit.
// Used by the top level; no other dependencies.
`ifndef SHA1_BLOCK_HASH_UNIT_MACROS_SVH
`define SHA1_BLOCK_HASH_UNIT_MACROS_SVH

// same-cycle implication
`define SHA1BH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHA1BH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sha1bh_pkg.sv =====
// Shared types and constants for the SHA-1 block hash unit.
// No dependencies.
package sha1bh_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWin  = 16;
  localparam int unsigned NumCv   = 5;
  localparam int unsigned NumRnd  = 80;
  localparam int unsigned RndW    = 7;
  localparam int unsigned IdxW    = 3;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } vars_t;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [RndW-1:0] RND_LAST = RndW'(NumRnd - 1);
  localparam logic [IdxW-1:0] IDX_LAST = IdxW'(NumCv - 1);

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (WordW - n));
  endfunction

endpackage

// ===== rtl/core/sha1_block_hash_unit.sv =====
// SHA-1 block hash unit: word intake, 16-word schedule shift line, round sequencer.
// Depends on sha1bh_pkg, sha1bh_round and sha1_block_hash_unit_macros.svh.
//
//  channel | dir | tdata                 | tuser                         | tlast
//  s_*     | in  | [31:0] message_word   | [0] start_message [1] final   | -
//  m_*     | out | [31:0] digest_word    | [2:0] word_index              | last_word
//
// A block takes 16 beats of intake, one beat a cycle while s_tvalid is high, then
// 80 rounds, one per cycle through the shared round unit, and then the chain add.
// A final block then emits five digest beats, each taken when m_tready is high.
// s_tready is low from the 16th beat until the block and its digest are done.
// rst is synchronous; it clears the sequencer and loads the initial chaining value.
`include "sha1_block_hash_unit_macros.svh"
module sha1_block_hash_unit import sha1bh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] message_word
  input  logic [1:0]  s_tuser,   // [0] start_message, [1] final_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ROUND  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]      state;
  logic [3:0]      word_count;
  logic [RndW-1:0] round_count;
  logic [IdxW-1:0] emit_idx;
  logic            emit_pending;

  word_t           win [NumWin];
  word_t           cv  [NumCv];
  vars_t           vars;
  vars_t           vars_next;
  word_t           w_new;

  logic            s_beat;
  logic            m_beat;

  assign s_tready = (state == ST_IDLE);
  assign s_beat   = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_EMIT);
  assign m_beat   = m_tvalid && m_tready;

  assign w_new = rotl(win[13] ^ win[8] ^ win[2] ^ win[0], 1);

  sha1bh_round u_round (
    .vars      (vars),
    .w         (win[0]),
    .rnd       (round_count),
    .vars_next (vars_next)
  );

  // schedule shift line: intake and expansion both push at the top
  always_ff @(posedge clk) begin
    if (s_beat || state == ST_ROUND) begin
      for (int i = 0; i < NumWin - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[NumWin-1] <= s_beat ? s_tdata : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat && word_count == 4'd15) begin
      vars <= '{a: cv[0], b: cv[1], c: cv[2], d: cv[3], e: cv[4]};
    end else if (state == ST_ROUND) begin
      vars <= vars_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      word_count   <= '0;
      round_count  <= '0;
      emit_idx     <= '0;
      emit_pending <= 1'b0;
      cv[0]        <= IV0;
      cv[1]        <= IV1;
      cv[2]        <= IV2;
      cv[3]        <= IV3;
      cv[4]        <= IV4;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_beat) begin
            if (word_count == 4'd0 && s_tuser[0]) begin
              cv[0] <= IV0;
              cv[1] <= IV1;
              cv[2] <= IV2;
              cv[3] <= IV3;
              cv[4] <= IV4;
            end
            if (s_tuser[1]) begin
              emit_pending <= 1'b1;
            end
            word_count <= word_count + 4'd1;
            if (word_count == 4'd15) begin
              state       <= ST_ROUND;
              round_count <= '0;
            end
          end
        end
        ST_ROUND: begin
          if (round_count == RND_LAST) begin
            state       <= ST_FINISH;
            round_count <= '0;
          end else begin
            round_count <= round_count + RndW'(1);
          end
        end
        ST_FINISH: begin
          cv[0] <= cv[0] + vars.a;
          cv[1] <= cv[1] + vars.b;
          cv[2] <= cv[2] + vars.c;
          cv[3] <= cv[3] + vars.d;
          cv[4] <= cv[4] + vars.e;
          emit_idx <= '0;
          if (emit_pending) begin
            state        <= ST_EMIT;
            emit_pending <= 1'b0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (m_beat) begin
            if (emit_idx == IDX_LAST) begin
              state    <= ST_IDLE;
              emit_idx <= '0;
            end else begin
              emit_idx <= emit_idx + IdxW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (emit_idx)
      3'd0:    m_tdata = cv[0];
      3'd1:    m_tdata = cv[1];
      3'd2:    m_tdata = cv[2];
      3'd3:    m_tdata = cv[3];
      default: m_tdata = cv[4];
    endcase
  end

  assign m_tuser = emit_idx;
  assign m_tlast = (emit_idx == IDX_LAST);

  `SHA1BH_ASSERT_NOW(a_ready_vs_out, clk, rst, m_tvalid, !s_tready, "intake open")
  `SHA1BH_ASSERT_NOW(a_rnd_range, clk, rst, state == ST_ROUND, round_count <= RND_LAST, "rnd")
  `SHA1BH_ASSERT_NEXT(a_rnd_done, clk, rst, round_count == RND_LAST, state == ST_FINISH, "end")
  `SHA1BH_ASSERT_NEXT(a_last_idle, clk, rst, m_beat && m_tlast, state == ST_IDLE, "close")
  `SHA1BH_ASSERT_NOW(a_emit_idx, clk, rst, m_tvalid, emit_idx <= IDX_LAST, "digest index")

endmodule

// ===== rtl/core/sha1bh_round.sv =====
// One SHA-1 round: round function, constant select and the five-term add.
// Depends on sha1bh_pkg.
module sha1bh_round import sha1bh_pkg::*; (
  input  vars_t           vars,
  input  word_t           w,
  input  logic [RndW-1:0] rnd,
  output vars_t           vars_next
);

  word_t f;
  word_t k;

  always_comb begin
    if (rnd < RndW'(20)) begin
      f = (vars.b & vars.c) ^ (~vars.b & vars.d);
      k = K0;
    end else if (rnd < RndW'(40)) begin
      f = vars.b ^ vars.c ^ vars.d;
      k = K1;
    end else if (rnd < RndW'(60)) begin
      f = (vars.b & vars.c) ^ (vars.b & vars.d) ^ (vars.c & vars.d);
      k = K2;
    end else begin
      f = vars.b ^ vars.c ^ vars.d;
      k = K3;
    end
  end

  always_comb begin
    vars_next.a = rotl(vars.a, 5) + f + vars.e + k + w;
    vars_next.b = vars.a;
    vars_next.c = rotl(vars.b, 30);
    vars_next.d = vars.c;
    vars_next.e = vars.d;
  end

endmodule
